[sv/gyi_pkg.sv]
// Shared types, codes and constants of the gyro yaw integrator.
package gyi_pkg;

    localparam int CALIB_MAX   = 256;
    localparam int GOOD_W      = $clog2(CALIB_MAX + 1);
    localparam int GZ_W        = 16;
    localparam int SUM_W       = GOOD_W + GZ_W;
    localparam int DIV_CNT_W   = $clog2(SUM_W + 1);
    localparam int TICK_W      = 32;
    localparam int YAW_W       = 56;
    localparam int LIM_W       = 40;
    localparam int CFG16_W     = 16;
    localparam int G_W         = GZ_W + 1;
    localparam int PROD_W      = G_W + TICK_W + 1;
    localparam int ACC_W       = YAW_W + 2;
    localparam int OP_W        = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = LIM_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG16_W-1:0] INTERVAL_RESET  = 16'd10;
    localparam logic [CFG16_W-1:0] DEAD_ZONE_RESET = 16'd5;
    localparam logic [LIM_W-1:0]   WRAP_RESET      = 40'd235800000;
    localparam logic [CFG16_W-1:0] MIN_GOOD_RESET  = 16'd100;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE     = 3'd0,
        OP_CAL_SAMPLE = 3'd1,
        OP_CAL_FINISH = 3'd2,
        OP_RESET_YAW  = 3'd3,
        OP_RESTART    = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_YAW_ENABLE = 3'd0,
        CFG_INTERVAL   = 3'd1,
        CFG_DEAD_ZONE  = 3'd2,
        CFG_WRAP_LIMIT = 3'd3,
        CFG_MIN_GOOD   = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_SAMPLE,
        CMD_CAL_SAMPLE,
        CMD_CAL_FINISH,
        CMD_RESET_YAW,
        CMD_RESTART
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MUL,
        BS_ADD,
        BS_DIV,
        BS_EXEC
    } t_back_state;

    typedef struct packed {
        logic               yaw_enable;
        logic [CFG16_W-1:0] interval_ms;
        logic [CFG16_W-1:0] dead_zone;
        logic [LIM_W-1:0]   wrap_limit;
        logic [CFG16_W-1:0] calib_min_good;
    } t_cfg;

    typedef struct packed {
        t_cmd                   cmd;
        logic [TICK_W-1:0]      now_ms;
        logic signed [GZ_W-1:0] gz_raw;
        logic                   read_ok;
    } t_item;

    typedef struct packed {
        logic signed [YAW_W-1:0] yaw_acc;
        logic signed [GZ_W-1:0]  gz_offset;
        logic                    yaw_changed;
        logic                    calib_failed;
    } t_result;

endpackage

[sv/gyi_front.sv]
// Front end: input register that accepts items and decodes the op into a command.
module gyi_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [gyi_pkg::OP_W-1:0]      i_op,
    input  logic [gyi_pkg::TICK_W-1:0]    i_now_ms,
    input  logic signed [gyi_pkg::GZ_W-1:0] i_gz_raw,
    input  logic                          i_read_ok,
    output logic                          o_push_valid,
    input  logic                          i_push_ready,
    output gyi_pkg::t_item                o_push_item
);

    logic           r_valid;
    logic           n_valid;
    gyi_pkg::t_item r_item;
    gyi_pkg::t_item n_item;
    logic           in_acc;

    assign o_in_ready   = !r_valid || i_push_ready;
    assign in_acc       = i_in_valid && o_in_ready;
    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    always_comb begin
        n_item.now_ms  = i_now_ms;
        n_item.gz_raw  = i_gz_raw;
        n_item.read_ok = i_read_ok;
        unique case (i_op)
            gyi_pkg::OP_SAMPLE:     n_item.cmd = gyi_pkg::CMD_SAMPLE;
            gyi_pkg::OP_CAL_SAMPLE: n_item.cmd = gyi_pkg::CMD_CAL_SAMPLE;
            gyi_pkg::OP_CAL_FINISH: n_item.cmd = gyi_pkg::CMD_CAL_FINISH;
            gyi_pkg::OP_RESET_YAW:  n_item.cmd = gyi_pkg::CMD_RESET_YAW;
            gyi_pkg::OP_RESTART:    n_item.cmd = gyi_pkg::CMD_RESTART;
            default:                n_item.cmd = gyi_pkg::CMD_NOP;
        endcase
    end

    always_comb begin
        if (in_acc) begin
            n_valid = 1'b1;
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= n_item;
        end
    end

endmodule

[sv/gyi_queue.sv]
// Short command queue between the front end and the back end.
module gyi_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push_valid,
    output logic                         o_push_ready,
    input  gyi_pkg::t_item               i_push_item,
    output logic                         o_pop_valid,
    input  logic                         i_pop_ready,
    output gyi_pkg::t_item               o_pop_item,
    output logic [gyi_pkg::QPTR_W:0]     o_count
);

    gyi_pkg::t_item                r_mem [gyi_pkg::QUEUE_DEPTH];
    logic [gyi_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [gyi_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [gyi_pkg::QPTR_W:0]      r_count;
    logic [gyi_pkg::QPTR_W:0]      n_count;
    logic                          push;
    logic                          pop;

    assign o_push_ready = r_count != (gyi_pkg::QPTR_W + 1)'(gyi_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign o_count      = r_count;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    assign n_count = r_count + (gyi_pkg::QPTR_W + 1)'(push) - (gyi_pkg::QPTR_W + 1)'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

[sv/gyi_div.sv]
// Restoring divider, one quotient bit per cycle, for the calibration average.
module gyi_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [gyi_pkg::SUM_W-1:0]    i_dividend,
    input  logic [gyi_pkg::GOOD_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [gyi_pkg::SUM_W-1:0]    o_quotient
);

    logic                             r_busy;
    logic                             r_done;
    logic [gyi_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [gyi_pkg::SUM_W-1:0]        r_quo;
    logic [gyi_pkg::GOOD_W-1:0]       r_rem;
    logic [gyi_pkg::GOOD_W-1:0]       r_div;
    logic [gyi_pkg::GOOD_W:0]         shifted;
    logic [gyi_pkg::GOOD_W:0]         diff;
    logic                             fits;
    logic [gyi_pkg::GOOD_W-1:0]       n_rem;
    logic [gyi_pkg::SUM_W-1:0]        n_quo;

    assign shifted = {r_rem, r_quo[gyi_pkg::SUM_W-1]};
    assign fits    = shifted >= {1'b0, r_div};
    assign diff    = shifted - {1'b0, r_div};
    assign n_rem   = fits ? diff[gyi_pkg::GOOD_W-1:0] : shifted[gyi_pkg::GOOD_W-1:0];
    assign n_quo   = {r_quo[gyi_pkg::SUM_W-2:0], fits};

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= gyi_pkg::DIV_CNT_W'(gyi_pkg::SUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == gyi_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

endmodule

[sv/gyi_back.sv]
// Back end: yaw and calibration state, multiply and wrap datapath, result register.
module gyi_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gyi_pkg::t_cfg    i_cfg,
    input  logic             i_pop_valid,
    output logic             o_pop_ready,
    input  gyi_pkg::t_item   i_pop_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output gyi_pkg::t_result o_result
);

    gyi_pkg::t_back_state                r_state;
    gyi_pkg::t_back_state                n_state;
    gyi_pkg::t_item                      r_item;
    gyi_pkg::t_item                      n_item;
    logic [gyi_pkg::TICK_W-1:0]          r_elapsed;
    logic [gyi_pkg::TICK_W-1:0]          n_elapsed;
    logic signed [gyi_pkg::G_W-1:0]      r_g;
    logic signed [gyi_pkg::G_W-1:0]      n_g;
    logic                                r_take;
    logic                                n_take;
    logic                                r_hit;
    logic                                n_hit;
    logic signed [gyi_pkg::PROD_W-1:0]   r_prod;
    logic signed [gyi_pkg::PROD_W-1:0]   n_prod;
    logic signed [gyi_pkg::ACC_W-1:0]    r_sum;
    logic signed [gyi_pkg::ACC_W-1:0]    n_sum;
    logic signed [gyi_pkg::YAW_W-1:0]    r_yaw;
    logic signed [gyi_pkg::YAW_W-1:0]    n_yaw;
    logic [gyi_pkg::TICK_W-1:0]          r_last_tick;
    logic [gyi_pkg::TICK_W-1:0]          n_last_tick;
    logic signed [gyi_pkg::GZ_W-1:0]     r_bias;
    logic signed [gyi_pkg::GZ_W-1:0]     n_bias;
    logic signed [gyi_pkg::SUM_W-1:0]    r_calib_sum;
    logic signed [gyi_pkg::SUM_W-1:0]    n_calib_sum;
    logic [gyi_pkg::GOOD_W-1:0]          r_calib_good;
    logic [gyi_pkg::GOOD_W-1:0]          n_calib_good;
    logic                                r_out_valid;
    logic                                n_out_valid;
    gyi_pkg::t_result                    r_out;
    gyi_pkg::t_result                    n_out;

    logic                                out_free;
    logic                                changed;
    logic                                failed;
    logic signed [gyi_pkg::G_W:0]        g_x;
    logic signed [gyi_pkg::G_W:0]        dz_s;
    logic                                dz_out;
    logic signed [gyi_pkg::ACC_W-1:0]    lim_s;
    logic signed [gyi_pkg::ACC_W-1:0]    wrapped;
    logic                                div_start;
    logic                                div_done;
    logic [gyi_pkg::SUM_W-1:0]           div_dividend;
    logic [gyi_pkg::SUM_W-1:0]           div_quo;
    logic [gyi_pkg::GZ_W-1:0]            quo16;

    gyi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_calib_good),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign out_free     = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_result     = r_out;

    assign g_x    = (gyi_pkg::G_W + 1)'(r_g);
    assign dz_s   = $signed({2'b00, i_cfg.dead_zone});
    assign dz_out = (g_x >= dz_s) || (g_x <= -dz_s);

    assign lim_s = $signed({{(gyi_pkg::ACC_W - gyi_pkg::LIM_W){1'b0}}, i_cfg.wrap_limit});

    always_comb begin
        if (r_sum > lim_s) begin
            wrapped = r_sum - lim_s;
        end else if (r_sum < -lim_s) begin
            wrapped = r_sum + lim_s;
        end else begin
            wrapped = r_sum;
        end
    end

    assign div_dividend = r_calib_sum[gyi_pkg::SUM_W-1] ? $unsigned(-r_calib_sum)
                                                        : $unsigned(r_calib_sum);
    assign quo16 = div_quo[gyi_pkg::GZ_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_elapsed    = r_elapsed;
        n_g          = r_g;
        n_take       = r_take;
        n_hit        = r_hit;
        n_prod       = r_prod;
        n_sum        = r_sum;
        n_yaw        = r_yaw;
        n_last_tick  = r_last_tick;
        n_bias       = r_bias;
        n_calib_sum  = r_calib_sum;
        n_calib_good = r_calib_good;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        o_pop_ready  = 1'b0;
        div_start    = 1'b0;
        changed      = 1'b0;
        failed       = 1'b0;
        unique case (r_state)
            gyi_pkg::BS_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_item    = i_pop_item;
                    n_elapsed = i_pop_item.now_ms - r_last_tick;
                    n_g       = gyi_pkg::G_W'($signed(i_pop_item.gz_raw))
                              - gyi_pkg::G_W'(r_bias);
                    if (i_pop_item.cmd == gyi_pkg::CMD_SAMPLE) begin
                        n_state = gyi_pkg::BS_MUL;
                    end else if (i_pop_item.cmd == gyi_pkg::CMD_CAL_FINISH
                                 && r_calib_good != '0) begin
                        div_start = 1'b1;
                        n_state   = gyi_pkg::BS_DIV;
                    end else begin
                        n_state = gyi_pkg::BS_EXEC;
                    end
                end
            end
            gyi_pkg::BS_MUL: begin
                n_prod  = r_g * $signed({1'b0, r_elapsed});
                n_take  = i_cfg.yaw_enable
                          && (r_elapsed >= {{(gyi_pkg::TICK_W - gyi_pkg::CFG16_W){1'b0}},
                                            i_cfg.interval_ms});
                n_hit   = n_take && r_item.read_ok && dz_out;
                n_state = gyi_pkg::BS_ADD;
            end
            gyi_pkg::BS_ADD: begin
                n_sum   = gyi_pkg::ACC_W'(r_yaw) + gyi_pkg::ACC_W'(r_prod);
                n_state = gyi_pkg::BS_EXEC;
            end
            gyi_pkg::BS_DIV: begin
                if (div_done) begin
                    n_state = gyi_pkg::BS_EXEC;
                end
            end
            gyi_pkg::BS_EXEC: begin
                if (out_free) begin
                    unique case (r_item.cmd)
                        gyi_pkg::CMD_SAMPLE: begin
                            if (r_take) begin
                                n_last_tick = r_item.now_ms;
                            end
                            if (r_hit) begin
                                n_yaw   = $signed(wrapped[gyi_pkg::YAW_W-1:0]);
                                changed = 1'b1;
                            end
                        end
                        gyi_pkg::CMD_CAL_SAMPLE: begin
                            if (r_item.read_ok
                                && r_calib_good < gyi_pkg::GOOD_W'(gyi_pkg::CALIB_MAX)) begin
                                n_calib_sum  = r_calib_sum
                                             + gyi_pkg::SUM_W'($signed(r_item.gz_raw));
                                n_calib_good = r_calib_good + 1'b1;
                            end
                        end
                        gyi_pkg::CMD_CAL_FINISH: begin
                            if (r_calib_good == '0) begin
                                n_bias = '0;
                            end else if (r_calib_sum[gyi_pkg::SUM_W-1]) begin
                                n_bias = $signed(-quo16);
                            end else begin
                                n_bias = $signed(quo16);
                            end
                            failed = gyi_pkg::CFG16_W'(r_calib_good) < i_cfg.calib_min_good;
                            n_calib_sum  = '0;
                            n_calib_good = '0;
                        end
                        gyi_pkg::CMD_RESET_YAW: begin
                            n_yaw       = '0;
                            n_last_tick = r_item.now_ms;
                        end
                        gyi_pkg::CMD_RESTART: begin
                            n_last_tick = r_item.now_ms;
                        end
                        gyi_pkg::CMD_NOP: begin
                        end
                    endcase
                    n_out_valid        = 1'b1;
                    n_out.yaw_acc      = n_yaw;
                    n_out.gz_offset    = n_bias;
                    n_out.yaw_changed  = changed;
                    n_out.calib_failed = failed;
                    n_state            = gyi_pkg::BS_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gyi_pkg::BS_IDLE;
            r_out_valid  <= 1'b0;
            r_yaw        <= '0;
            r_last_tick  <= '0;
            r_bias       <= '0;
            r_calib_sum  <= '0;
            r_calib_good <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_yaw        <= n_yaw;
            r_last_tick  <= n_last_tick;
            r_bias       <= n_bias;
            r_calib_sum  <= n_calib_sum;
            r_calib_good <= n_calib_good;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_elapsed <= n_elapsed;
        r_g       <= n_g;
        r_take    <= n_take;
        r_hit     <= n_hit;
        r_prod    <= n_prod;
        r_sum     <= n_sum;
        r_out     <= n_out;
    end

endmodule

[sv/gyro_yaw_integrator.sv]
// Top level of the gyro yaw integrator: config registers, front end, queue, back end.
//
// channel   dir  handshake                  payload
// config    in   i_cfg_we                   i_cfg_idx, i_cfg_data
// items     in   i_in_valid / o_in_ready    i_op, i_now_ms, i_gz_raw, i_read_ok
// results   out  o_out_valid / i_out_ready  o_yaw_acc, o_gz_offset, o_yaw_changed,
//                                           o_calib_failed
//
// A sample goes through the back-end steps pop, multiply, add, then wrap and commit.
// Calibration samples, yaw reset, timing restart and unused ops go from pop to commit.
// Calibration finish with good reads waits in the divide step for the one-bit-per-cycle
// divider before it commits; with no good reads it goes from pop to commit.
// The front register and two-entry queue add latency only.
// Synchronous active-low reset sets config defaults and zeroes control, yaw and calib state.
// A held result stalls the back end in its commit step; the queue takes items until full.
module gyro_yaw_integrator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gyi_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gyi_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [gyi_pkg::OP_W-1:0]            i_op,
    input  logic [gyi_pkg::TICK_W-1:0]          i_now_ms,
    input  logic signed [gyi_pkg::GZ_W-1:0]     i_gz_raw,
    input  logic                                i_read_ok,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [gyi_pkg::YAW_W-1:0]    o_yaw_acc,
    output logic signed [gyi_pkg::GZ_W-1:0]     o_gz_offset,
    output logic                                o_yaw_changed,
    output logic                                o_calib_failed
);

    gyi_pkg::t_cfg                 r_cfg;
    logic                          push_valid;
    logic                          push_ready;
    gyi_pkg::t_item                push_item;
    logic                          q_pop_valid;
    logic                          q_pop_ready;
    gyi_pkg::t_item                q_pop_item;
    logic [gyi_pkg::QPTR_W:0]      q_count;
    gyi_pkg::t_result              result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.yaw_enable     <= 1'b0;
            r_cfg.interval_ms    <= gyi_pkg::INTERVAL_RESET;
            r_cfg.dead_zone      <= gyi_pkg::DEAD_ZONE_RESET;
            r_cfg.wrap_limit     <= gyi_pkg::WRAP_RESET;
            r_cfg.calib_min_good <= gyi_pkg::MIN_GOOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gyi_pkg::CFG_YAW_ENABLE: r_cfg.yaw_enable  <= i_cfg_data[0];
                gyi_pkg::CFG_INTERVAL:   r_cfg.interval_ms <= i_cfg_data[gyi_pkg::CFG16_W-1:0];
                gyi_pkg::CFG_DEAD_ZONE:  r_cfg.dead_zone   <= i_cfg_data[gyi_pkg::CFG16_W-1:0];
                gyi_pkg::CFG_WRAP_LIMIT: r_cfg.wrap_limit  <= i_cfg_data[gyi_pkg::LIM_W-1:0];
                gyi_pkg::CFG_MIN_GOOD: begin
                    r_cfg.calib_min_good <= i_cfg_data[gyi_pkg::CFG16_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    gyi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_now_ms     (i_now_ms),
        .i_gz_raw     (i_gz_raw),
        .i_read_ok    (i_read_ok),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    gyi_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (q_pop_ready),
        .o_pop_item   (q_pop_item),
        .o_count      (q_count)
    );

    gyi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (q_pop_valid),
        .o_pop_ready (q_pop_ready),
        .i_pop_item  (q_pop_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_yaw_acc      = result.yaw_acc;
    assign o_gz_offset    = result.gz_offset;
    assign o_yaw_changed  = result.yaw_changed;
    assign o_calib_failed = result.calib_failed;

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_yaw_changed && o_calib_failed))
        else $error("yaw_changed and calib_failed both set on one item");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= (gyi_pkg::QPTR_W + 1)'(gyi_pkg::QUEUE_DEPTH))
        else $error("command queue count beyond its depth");

    a_queue_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop_valid == (q_count != '0))
        else $error("queue pop valid disagrees with its count");

endmodule

[bench/gyro_yaw_integrator_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the gyro yaw integrator: directed cases, then random phases.
module gyro_yaw_integrator_tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 130;
    localparam int PHASES      = 6;
    localparam logic [gyi_pkg::LIM_W-1:0] WRAP_MAX = '1;

    class yaw_shadow;
        logic                             yaw_enable;
        logic [gyi_pkg::CFG16_W-1:0]      interval;
        logic [gyi_pkg::CFG16_W-1:0]      dead_zone;
        logic [gyi_pkg::LIM_W-1:0]        wrap_limit;
        logic [gyi_pkg::CFG16_W-1:0]      min_good;
        logic signed [gyi_pkg::YAW_W-1:0] yaw;
        logic [gyi_pkg::TICK_W-1:0]       last_tick;
        int                               bias;
        int                               cal_sum;
        int                               cal_good;
        gyi_pkg::t_result                 readings_due[$];
        int                               mismatches;

        function new();
            yaw_enable = 1'b0;
            interval   = gyi_pkg::INTERVAL_RESET;
            dead_zone  = gyi_pkg::DEAD_ZONE_RESET;
            wrap_limit = gyi_pkg::WRAP_RESET;
            min_good   = gyi_pkg::MIN_GOOD_RESET;
            yaw        = '0;
            last_tick  = '0;
            bias       = 0;
            cal_sum    = 0;
            cal_good   = 0;
            mismatches = 0;
        endfunction

        function void set_reg(gyi_pkg::t_cfg_idx idx, logic [gyi_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                gyi_pkg::CFG_YAW_ENABLE: yaw_enable = data[0];
                gyi_pkg::CFG_INTERVAL:   interval   = data[gyi_pkg::CFG16_W-1:0];
                gyi_pkg::CFG_DEAD_ZONE:  dead_zone  = data[gyi_pkg::CFG16_W-1:0];
                gyi_pkg::CFG_WRAP_LIMIT: wrap_limit = data[gyi_pkg::LIM_W-1:0];
                gyi_pkg::CFG_MIN_GOOD:   min_good   = data[gyi_pkg::CFG16_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_item(logic [gyi_pkg::OP_W-1:0] op, logic [gyi_pkg::TICK_W-1:0] now,
                                logic signed [gyi_pkg::GZ_W-1:0] gz, logic ok);
            gyi_pkg::t_result           r;
            logic [gyi_pkg::TICK_W-1:0] elapsed;
            int                         g;
            int                         dz;
            longint                     span;
            longint                     lim;
            longint                     acc;
            r.yaw_changed  = 1'b0;
            r.calib_failed = 1'b0;
            case (op)
                gyi_pkg::OP_SAMPLE: begin
                    elapsed = now - last_tick;
                    if (yaw_enable && elapsed >= interval) begin
                        last_tick = now;
                        g  = int'(gz) - bias;
                        dz = dead_zone;
                        if (ok && !(g > -dz && g < dz)) begin
                            span = elapsed;
                            lim  = wrap_limit;
                            acc  = longint'(yaw) + longint'(g) * span;
                            if (acc > lim) acc = acc - lim;
                            if (acc < -lim) acc = acc + lim;
                            yaw = acc[gyi_pkg::YAW_W-1:0];
                            r.yaw_changed = 1'b1;
                        end
                    end
                end
                gyi_pkg::OP_CAL_SAMPLE: begin
                    if (ok && cal_good < gyi_pkg::CALIB_MAX) begin
                        cal_sum  = cal_sum + int'(gz);
                        cal_good = cal_good + 1;
                    end
                end
                gyi_pkg::OP_CAL_FINISH: begin
                    bias = (cal_good > 0) ? cal_sum / cal_good : 0;
                    r.calib_failed = (cal_good < int'(min_good));
                    cal_sum  = 0;
                    cal_good = 0;
                end
                gyi_pkg::OP_RESET_YAW: begin
                    yaw       = '0;
                    last_tick = now;
                end
                gyi_pkg::OP_RESTART: last_tick = now;
                default: ;
            endcase
            r.yaw_acc   = yaw;
            r.gz_offset = bias[gyi_pkg::GZ_W-1:0];
            readings_due.push_back(r);
        endfunction

        function void match_reading(logic signed [gyi_pkg::YAW_W-1:0] yaw_acc,
                                    logic signed [gyi_pkg::GZ_W-1:0] gz_offset,
                                    logic yaw_changed, logic calib_failed);
            gyi_pkg::t_result want;
            if (readings_due.size() == 0) begin
                $display("%0t: result with no item outstanding, yaw_acc %0d", $time, yaw_acc);
                mismatches++;
                return;
            end
            want = readings_due.pop_front();
            if (want.yaw_acc !== yaw_acc) begin
                $display("%0t: yaw_acc expected %0d, actual %0d", $time, want.yaw_acc, yaw_acc);
                mismatches++;
            end
            if (want.gz_offset !== gz_offset) begin
                $display("%0t: gz_offset expected %0d, actual %0d",
                         $time, want.gz_offset, gz_offset);
                mismatches++;
            end
            if (want.yaw_changed !== yaw_changed) begin
                $display("%0t: yaw_changed expected %0b, actual %0b",
                         $time, want.yaw_changed, yaw_changed);
                mismatches++;
            end
            if (want.calib_failed !== calib_failed) begin
                $display("%0t: calib_failed expected %0b, actual %0b",
                         $time, want.calib_failed, calib_failed);
                mismatches++;
            end
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [gyi_pkg::CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [gyi_pkg::CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    logic [gyi_pkg::OP_W-1:0]          i_op = '0;
    logic [gyi_pkg::TICK_W-1:0]        i_now_ms = '0;
    logic signed [gyi_pkg::GZ_W-1:0]   i_gz_raw = '0;
    logic                              i_read_ok = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic signed [gyi_pkg::YAW_W-1:0]  o_yaw_acc;
    logic signed [gyi_pkg::GZ_W-1:0]   o_gz_offset;
    logic                              o_yaw_changed;
    logic                              o_calib_failed;

    yaw_shadow shadow = new();

    int stall_left = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    gyro_yaw_integrator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_now_ms       (i_now_ms),
        .i_gz_raw       (i_gz_raw),
        .i_read_ok      (i_read_ok),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_yaw_acc      (o_yaw_acc),
        .o_gz_offset    (o_gz_offset),
        .o_yaw_changed  (o_yaw_changed),
        .o_calib_failed (o_calib_failed)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left  <= $urandom_range(0, 12);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            shadow.match_reading(o_yaw_acc, o_gz_offset, o_yaw_changed, o_calib_failed);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** gyro_yaw_integrator: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input gyi_pkg::t_cfg_idx idx,
                             input logic [gyi_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        shadow.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic [gyi_pkg::OP_W-1:0] op,
                             input logic [gyi_pkg::TICK_W-1:0] now,
                             input logic signed [gyi_pkg::GZ_W-1:0] gz, input logic ok);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_now_ms   <= now;
        i_gz_raw   <= gz;
        i_read_ok  <= ok;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        shadow.take_item(op, now, gz, ok);
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (shadow.readings_due.size() != 0);
    endtask

    initial begin
        logic [gyi_pkg::TICK_W-1:0]      tick;
        logic [gyi_pkg::TICK_W-1:0]      hop;
        logic signed [gyi_pkg::GZ_W-1:0] base;
        logic signed [gyi_pkg::GZ_W-1:0] gz;
        int                              n;
        int                              pick;
        int                              burst;

        repeat (7) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        gap_pct   = 20;
        stall_pct = 20;

        // disabled block leaves yaw and timing alone
        send_item(gyi_pkg::OP_SAMPLE, 32'd100, 16'sd1000, 1'b1);
        drain();
        write_reg(gyi_pkg::CFG_YAW_ENABLE, 1);
        write_reg(gyi_pkg::CFG_INTERVAL, 10);
        write_reg(gyi_pkg::CFG_DEAD_ZONE, 5);
        write_reg(gyi_pkg::CFG_WRAP_LIMIT, gyi_pkg::WRAP_RESET);
        write_reg(gyi_pkg::CFG_MIN_GOOD, 3);

        send_item(gyi_pkg::OP_CAL_SAMPLE, 32'd200, 16'sh7FFF, 1'b1);
        send_item(gyi_pkg::OP_CAL_SAMPLE, 32'd201, 16'sh8000, 1'b1);
        send_item(gyi_pkg::OP_CAL_SAMPLE, 32'd202, 16'sd555, 1'b0);
        send_item(gyi_pkg::OP_CAL_SAMPLE, 32'd203, 16'sd100, 1'b1);
        send_item(gyi_pkg::OP_CAL_FINISH, 32'd204, 16'sd0, 1'b1);
        send_item(gyi_pkg::OP_CAL_FINISH, 32'd205, 16'sd0, 1'b1);
        send_item(gyi_pkg::OP_CAL_SAMPLE, 32'd206, -16'sd7, 1'b1);
        send_item(gyi_pkg::OP_CAL_SAMPLE, 32'd207, -16'sd8, 1'b1);
        send_item(gyi_pkg::OP_CAL_FINISH, 32'd208, 16'sd0, 1'b1);
        send_item(gyi_pkg::OP_RESTART, 32'd1000, 16'sd0, 1'b1);
        send_item(gyi_pkg::OP_SAMPLE, 32'd1005, 16'sh7FFF, 1'b1);
        send_item(gyi_pkg::OP_SAMPLE, 32'd1010, 16'sh7FFF, 1'b1);
        send_item(gyi_pkg::OP_SAMPLE, 32'd1030, -16'sd9, 1'b1);
        send_item(gyi_pkg::OP_SAMPLE, 32'd1040, -16'sd2, 1'b1);
        send_item(gyi_pkg::OP_SAMPLE, 32'd1050, 16'sd0, 1'b0);
        send_item(gyi_pkg::OP_SAMPLE, 32'hFFFF_FFF0, 16'sh8000, 1'b1);
        send_item(gyi_pkg::OP_SAMPLE, 32'h0000_0010, 16'sh7FFF, 1'b1);
        for (int k = gyi_pkg::OP_RESTART + 1; k < (1 << gyi_pkg::OP_W); k++)
            send_item(k[gyi_pkg::OP_W-1:0], $urandom, gyi_pkg::GZ_W'($urandom), 1'b1);
        send_item(gyi_pkg::OP_RESET_YAW, 32'h20, 16'sd0, 1'b1);
        send_item(gyi_pkg::OP_SAMPLE, 32'h30, 16'sd1234, 1'b1);
        drain();

        // zero interval, zero dead zone, zero wrap limit, then drive the sum past 56 bits
        write_reg(gyi_pkg::CFG_INTERVAL, 0);
        write_reg(gyi_pkg::CFG_DEAD_ZONE, 0);
        write_reg(gyi_pkg::CFG_WRAP_LIMIT, 0);
        tick = 32'h30;
        send_item(gyi_pkg::OP_SAMPLE, tick, -16'sd7, 1'b1);
        send_item(gyi_pkg::OP_SAMPLE, tick, 16'sd40, 1'b1);
        repeat (3) send_item(gyi_pkg::OP_CAL_SAMPLE, tick, 16'sh8000, 1'b1);
        send_item(gyi_pkg::OP_CAL_FINISH, tick, 16'sd0, 1'b1);
        repeat (140) begin
            tick = tick + 32'hFFFF_FFFF;
            send_item(gyi_pkg::OP_SAMPLE, tick,
                      16'sh7FFF - gyi_pkg::GZ_W'($urandom_range(0, 200)), 1'b1);
        end
        drain();
        write_reg(gyi_pkg::CFG_WRAP_LIMIT, WRAP_MAX);
        repeat (5) begin
            tick = tick + 32'hFFFF_FFFF;
            send_item(gyi_pkg::OP_SAMPLE, tick, gyi_pkg::GZ_W'($urandom), 1'b1);
        end
        drain();

        // calibration past its cap, then finish with nothing gathered
        write_reg(gyi_pkg::CFG_MIN_GOOD, 16'hFFFF);
        repeat (300) begin
            tick = tick + $urandom_range(1, 20);
            send_item(gyi_pkg::OP_CAL_SAMPLE, tick, gyi_pkg::GZ_W'($urandom),
                      $urandom_range(0, 9) != 0);
        end
        send_item(gyi_pkg::OP_CAL_FINISH, tick, 16'sd0, 1'b1);
        drain();
        write_reg(gyi_pkg::CFG_MIN_GOOD, 0);
        send_item(gyi_pkg::OP_CAL_FINISH, tick, 16'sd0, 1'b1);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 15;
                    default: gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end
            write_reg(gyi_pkg::CFG_YAW_ENABLE, $urandom_range(0, 5) != 0);
            case ($urandom_range(0, 4))
                0: write_reg(gyi_pkg::CFG_INTERVAL, 0);
                1: write_reg(gyi_pkg::CFG_INTERVAL, $urandom_range(1, 20));
                2: write_reg(gyi_pkg::CFG_INTERVAL, 16'hFFFF);
                3: write_reg(gyi_pkg::CFG_INTERVAL, $urandom_range(0, 65535));
                default: write_reg(gyi_pkg::CFG_INTERVAL, gyi_pkg::INTERVAL_RESET);
            endcase
            case ($urandom_range(0, 4))
                0: write_reg(gyi_pkg::CFG_DEAD_ZONE, 0);
                1: write_reg(gyi_pkg::CFG_DEAD_ZONE, $urandom_range(1, 50));
                2: write_reg(gyi_pkg::CFG_DEAD_ZONE, 16'hFFFF);
                3: write_reg(gyi_pkg::CFG_DEAD_ZONE, $urandom_range(0, 65535));
                default: write_reg(gyi_pkg::CFG_DEAD_ZONE, gyi_pkg::DEAD_ZONE_RESET);
            endcase
            case ($urandom_range(0, 4))
                0: write_reg(gyi_pkg::CFG_WRAP_LIMIT, 1);
                1: write_reg(gyi_pkg::CFG_WRAP_LIMIT, WRAP_MAX);
                2: write_reg(gyi_pkg::CFG_WRAP_LIMIT, {$urandom, $urandom});
                3: write_reg(gyi_pkg::CFG_WRAP_LIMIT, 0);
                default: write_reg(gyi_pkg::CFG_WRAP_LIMIT, gyi_pkg::WRAP_RESET);
            endcase
            if ($urandom_range(0, 1) != 0)
                write_reg(gyi_pkg::CFG_MIN_GOOD, $urandom_range(0, 20));
            else
                write_reg(gyi_pkg::CFG_MIN_GOOD, $urandom_range(0, 65535));

            n = 0;
            while (n < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    case ($urandom_range(0, 9))
                        0, 1: hop = $urandom_range(0, 30);
                        2: hop = $urandom;
                        default: hop = shadow.interval + $urandom_range(0, 15);
                    endcase
                    tick = tick + hop;
                    if ($urandom_range(0, 1) != 0)
                        gz = gyi_pkg::GZ_W'($urandom);
                    else
                        gz = gyi_pkg::GZ_W'(shadow.bias + $urandom_range(0, 40) - 20);
                    send_item(gyi_pkg::OP_SAMPLE, tick, gz, $urandom_range(0, 9) != 0);
                    n++;
                end else if (pick < 80) begin
                    base  = gyi_pkg::GZ_W'($urandom);
                    burst = $urandom_range(1, 12);
                    repeat (burst) begin
                        tick = tick + $urandom_range(1, 20);
                        send_item(gyi_pkg::OP_CAL_SAMPLE, tick,
                                  base + gyi_pkg::GZ_W'($urandom_range(0, 64)) - 16'sd32,
                                  $urandom_range(0, 9) != 0);
                        n++;
                    end
                    send_item(gyi_pkg::OP_CAL_FINISH, tick, gyi_pkg::GZ_W'($urandom), 1'b1);
                    n++;
                end else if (pick < 88) begin
                    tick = tick + $urandom_range(0, 100);
                    send_item(gyi_pkg::OP_RESET_YAW, tick, gyi_pkg::GZ_W'($urandom),
                              $urandom_range(0, 1));
                    n++;
                end else if (pick < 95) begin
                    tick = tick + $urandom;
                    send_item(gyi_pkg::OP_RESTART, tick, gyi_pkg::GZ_W'($urandom),
                              $urandom_range(0, 1));
                    n++;
                end else begin
                    send_item(gyi_pkg::OP_W'($urandom_range(0, (1 << gyi_pkg::OP_W) - 1)),
                              $urandom, gyi_pkg::GZ_W'($urandom), $urandom_range(0, 1));
                    n++;
                end
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.readings_due.size() == 0)
            $display("** gyro_yaw_integrator: PASSED **");
        else
            $display("** gyro_yaw_integrator: FAILED **");
        $finish;
    end

endmodule
